@@ rtl/dtfx_pkg.sv @@
// Shared types and constants for the decimal text to fixed point converter.
`default_nettype none
package dtfx_pkg;

	typedef logic [7:0]         char_t;
	typedef logic signed [44:0] value_t;

	typedef enum logic [2:0] {
		PH_START = 3'b001,
		PH_INT   = 3'b010,
		PH_FRAC  = 3'b100
	} phase_t;

	localparam char_t CH_MINUS = 8'h2D;
	localparam char_t CH_POINT = 8'h2E;
	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_NINE  = 8'h39;

	localparam int POW10_W = 27;
	localparam logic [POW10_W-1:0] POW10 [0:8] = '{
		27'd1, 27'd10, 27'd100, 27'd1000, 27'd10000, 27'd100000,
		27'd1000000, 27'd10000000, 27'd100000000
	};

endpackage
`default_nettype wire

@@ rtl/dtfx_text_if.sv @@
// Character input channel: valid/ready with one character and its end mark.
`default_nettype none
interface dtfx_text_if
	import dtfx_pkg::*;
	();
	logic  valid;
	logic  ready;
	char_t char_code;
	logic  last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink   (input valid, input char_code, input last_char, output ready);
endinterface
`default_nettype wire

@@ rtl/dtfx_result_if.sv @@
// Result output channel: valid/ready with the scaled value and the error flag.
`default_nettype none
interface dtfx_result_if
	import dtfx_pkg::*;
	();
	logic   valid;
	logic   ready;
	value_t scaled_value;
	logic   malformed;

	modport source (output valid, output scaled_value, output malformed, input ready);
	modport sink   (input valid, input scaled_value, input malformed, output ready);
endinterface
`default_nettype wire

@@ rtl/decimal_text_to_fixed_point_top.sv @@
// Decimal text to fixed point converter: one character per transfer, one result per string.
// Takes one character per cycle, back to back, unless a marked character waits on a stalled
// result register. Each character passes an input register, then one step of the parser
// updates a running value that is kept already scaled by 10^FRAC_DIGITS and already signed
// (integer digit: value times ten plus a digit weight; fraction digit: add the digit times
// its place weight), so the marked last character passes from the input register straight
// into the result register. A stalled result register holds back the next marked character
// and everything behind it, while plain characters ahead of it keep flowing. Errors (bad
// character, no integer digit, nonzero digit past FRAC_DIGITS fraction digits, more than
// MAX_INT_DIGITS integer digits) give malformed = 1 with scaled_value = 0.
`default_nettype none
module decimal_text_to_fixed_point_top
	import dtfx_pkg::*;
	#(
		parameter int MAX_INT_DIGITS = 9,
		parameter int FRAC_DIGITS    = 4
	)
	(
		input  logic           clk,
		input  logic           arst_n,
		dtfx_text_if.sink      text,
		dtfx_result_if.source  result
	);

	localparam int ICNT_W = $clog2(MAX_INT_DIGITS + 1);
	localparam int FCNT_W = $clog2(FRAC_DIGITS + 1);
	localparam int TERM_W = POW10_W + 4;
	localparam logic [POW10_W-1:0] INT_WEIGHT = POW10[FRAC_DIGITS];
	localparam logic [ICNT_W-1:0]  INT_MAX    = ICNT_W'(MAX_INT_DIGITS);
	localparam logic [FCNT_W-1:0]  FRAC_MAX   = FCNT_W'(FRAC_DIGITS);
	localparam logic [3:0]         FRAC_TOP   = 4'(FRAC_DIGITS - 1);

	logic        valid_s1;
	char_t       char_s1;
	logic        last_s1;

	phase_t              phase_q, phase_d;
	logic                neg_q, neg_d;
	logic [44:0]         acc_q, acc_d;
	logic [ICNT_W-1:0]   icnt_q, icnt_d;
	logic [FCNT_W-1:0]   fcnt_q, fcnt_d;
	logic                err_q, err_d;

	logic        out_valid_q;
	value_t      value_q;
	logic        malformed_q;

	logic        process;
	logic        is_digit;
	logic [3:0]  digit;
	logic [3:0]  frac_idx;
	logic [TERM_W-1:0] int_term, frac_term;
	logic [44:0] acc_x10, int_acc, frac_acc;
	logic        bad;

	assign process    = valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign text.ready = !valid_s1 || process;

	assign is_digit  = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
	assign digit     = char_s1[3:0];
	assign frac_idx  = FRAC_TOP - 4'(fcnt_q);
	assign int_term  = TERM_W'(digit) * TERM_W'(INT_WEIGHT);
	assign frac_term = TERM_W'(digit) * TERM_W'(POW10[frac_idx]);
	assign acc_x10   = (acc_q << 3) + (acc_q << 1);
	assign int_acc   = neg_q ? acc_x10 - 45'(int_term) : acc_x10 + 45'(int_term);
	assign frac_acc  = neg_q ? acc_q - 45'(frac_term) : acc_q + 45'(frac_term);

	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		acc_d   = acc_q;
		icnt_d  = icnt_q;
		fcnt_d  = fcnt_q;
		err_d   = err_q;
		if (!err_q) begin
			case (phase_q)
				PH_START, PH_INT: begin
					if (char_s1 == CH_MINUS && phase_q == PH_START) begin
						neg_d   = 1'b1;
						phase_d = PH_INT;
					end else if (char_s1 == CH_POINT) begin
						phase_d = PH_FRAC;
					end else if (is_digit) begin
						phase_d = PH_INT;
						if (icnt_q >= INT_MAX) begin
							err_d = 1'b1;
						end else begin
							acc_d  = int_acc;
							icnt_d = icnt_q + ICNT_W'(1);
						end
					end else begin
						err_d = 1'b1;
					end
				end
				PH_FRAC: begin
					if (!is_digit) begin
						err_d = 1'b1;
					end else if (fcnt_q < FRAC_MAX) begin
						acc_d  = frac_acc;
						fcnt_d = fcnt_q + FCNT_W'(1);
					end else if (digit != 4'd0) begin
						err_d = 1'b1;
					end
				end
				default: err_d = 1'b1;
			endcase
		end
	end

	assign bad = err_d || (icnt_d == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_q     <= PH_START;
			neg_q       <= 1'b0;
			acc_q       <= '0;
			icnt_q      <= '0;
			fcnt_q      <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (text.ready) begin
				valid_s1 <= text.valid;
			end
			if (process) begin
				if (last_s1) begin
					phase_q <= PH_START;
					neg_q   <= 1'b0;
					acc_q   <= '0;
					icnt_q  <= '0;
					fcnt_q  <= '0;
					err_q   <= 1'b0;
				end else begin
					phase_q <= phase_d;
					neg_q   <= neg_d;
					acc_q   <= acc_d;
					icnt_q  <= icnt_d;
					fcnt_q  <= fcnt_d;
					err_q   <= err_d;
				end
			end
			if (process && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			char_s1 <= text.char_code;
			last_s1 <= text.last_char;
		end
		if (process && last_s1) begin
			value_q     <= bad ? '0 : value_t'(acc_d);
			malformed_q <= bad;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.scaled_value = value_q;
	assign result.malformed    = malformed_q;

endmodule
`default_nettype wire

@@ rtl/dtfx_checker.sv @@
// Port-level checks for the converter, bound to the top level.
`default_nettype none
module dtfx_checker
	import dtfx_pkg::*;
	(
		input logic   clk,
		input logic   arst_n,
		input logic   text_ready,
		input logic   result_valid,
		input logic   result_ready,
		input value_t scaled_value,
		input logic   malformed
	);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped before transfer");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(scaled_value) && $stable(malformed))
		else $error("result changed while stalled");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && malformed |-> scaled_value == '0)
		else $error("malformed result carries a nonzero value");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!text_ready |-> result_valid && !result_ready)
		else $error("input stalled without a blocked result");

endmodule

bind decimal_text_to_fixed_point_top dtfx_checker u_dtfx_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.text_ready   (text.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.scaled_value (result.scaled_value),
	.malformed    (result.malformed)
);
`default_nettype wire

@@ verif/decimal_text_to_fixed_point_top_test.sv @@
// Self-checking testbench for the decimal text to fixed point converter.
module decimal_text_to_fixed_point_top_test
	import dtfx_pkg::*;
	();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_INT_DIGITS = 9;
	localparam int FRAC_DIGITS = 4;
	localparam longint unsigned SCALE = 64'd10 ** FRAC_DIGITS;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		char_t code;
		logic  last;
	} text_char_t;

	typedef struct {
		value_t value;
		logic   bad;
	} fixed_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dtfx_text_if text();
	dtfx_result_if result();

	decimal_text_to_fixed_point_top #(
		.MAX_INT_DIGITS(MAX_INT_DIGITS),
		.FRAC_DIGITS(FRAC_DIGITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text),
		.result(result)
	);

	text_char_t pending_chars[$];
	fixed_result_t expected_results[$];
	int chars_offered = 0;
	int chars_taken = 0;
	int chars_queued = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int hold_left = 0;
	bit calm = 1'b0;
	bit hold_off_req = 1'b0;

	phase_t parse_state = PH_START;
	logic text_negative = 1'b0;
	longint unsigned int_part = 0;
	int int_digits = 0;
	longint unsigned frac_part = 0;
	int frac_digits = 0;
	logic have_int_digit = 1'b0;
	logic text_bad = 1'b0;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic bit skip_cycle();
		return !calm && ($urandom_range(0, 99) < 14);
	endfunction

	task automatic clear_parse();
		parse_state = PH_START;
		text_negative = 1'b0;
		int_part = 0;
		int_digits = 0;
		frac_part = 0;
		frac_digits = 0;
		have_int_digit = 1'b0;
		text_bad = 1'b0;
	endtask

	task automatic add_int_digit(input logic [3:0] d);
		if (int_digits >= MAX_INT_DIGITS) begin
			text_bad = 1'b1;
		end else begin
			int_part = int_part * 10 + d;
			int_digits++;
			have_int_digit = 1'b1;
		end
	endtask

	task automatic predict_char(input char_t c, input logic last);
		logic is_digit;
		logic [3:0] d;
		longint unsigned frac;
		longint unsigned mag;
		fixed_result_t r;
		int k;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		d = 4'(c - CH_ZERO);
		if (!text_bad) begin
			case (parse_state)
				PH_START: begin
					if (c == CH_MINUS) begin
						text_negative = 1'b1;
						parse_state = PH_INT;
					end else if (c == CH_POINT) begin
						parse_state = PH_FRAC;
					end else if (is_digit) begin
						parse_state = PH_INT;
						add_int_digit(d);
					end else begin
						text_bad = 1'b1;
					end
				end
				PH_INT: begin
					if (c == CH_POINT)
						parse_state = PH_FRAC;
					else if (is_digit)
						add_int_digit(d);
					else
						text_bad = 1'b1;
				end
				PH_FRAC: begin
					if (!is_digit) begin
						text_bad = 1'b1;
					end else if (frac_digits < FRAC_DIGITS) begin
						frac_part = frac_part * 10 + d;
						frac_digits++;
					end else if (d != 0) begin
						text_bad = 1'b1;
					end
				end
				default: begin
					text_bad = 1'b1;
				end
			endcase
		end
		if (last) begin
			if (!have_int_digit)
				text_bad = 1'b1;
			if (text_bad) begin
				r.value = '0;
				r.bad = 1'b1;
			end else begin
				frac = frac_part;
				for (k = frac_digits; k < FRAC_DIGITS; k++)
					frac = frac * 10;
				mag = int_part * SCALE + frac;
				r.value = text_negative ? -value_t'(mag) : value_t'(mag);
				r.bad = 1'b0;
			end
			expected_results.insert(expected_results.size(), r);
			clear_parse();
		end
	endtask

	task automatic report_mismatch(input string what, input fixed_result_t want);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t ns: %s: expected value %0d malformed %0b, got value %0d malformed %0b",
				$time, what, want.value, want.bad, result.scaled_value, result.malformed);
	endtask

	task automatic add_chars(input char_t s[$]);
		int k;
		text_char_t item;
		for (k = 0; k < s.size(); k++) begin
			item.code = s[k];
			item.last = (k == s.size() - 1);
			pending_chars.insert(pending_chars.size(), item);
		end
		chars_queued += s.size();
	endtask

	task automatic queue_text(input string s);
		char_t chars[$];
		int k;
		for (k = 0; k < s.len(); k++)
			chars.insert(chars.size(), char_t'(s[k]));
		add_chars(chars);
	endtask

	task automatic queue_random_string();
		char_t s[$];
		int kind;
		int n;
		int k;
		int pos;
		bit all_nines;
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			n = $urandom_range(1, 4);
			repeat (n) s.insert(s.size(), char_t'($urandom_range(0, 255)));
		end else begin
			all_nines = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 1))
				s.insert(s.size(), CH_MINUS);
			if (all_nines)
				n = MAX_INT_DIGITS;
			else if ($urandom_range(0, 9) == 0)
				n = MAX_INT_DIGITS + 1;
			else
				n = $urandom_range(1, MAX_INT_DIGITS);
			repeat (n)
				s.insert(s.size(),
					all_nines ? CH_NINE : char_t'(CH_ZERO + $urandom_range(0, 9)));
			if ($urandom_range(0, 9) < 6) begin
				s.insert(s.size(), CH_POINT);
				n = all_nines ? FRAC_DIGITS : $urandom_range(0, FRAC_DIGITS + 2);
				for (k = 0; k < n; k++) begin
					if (k >= FRAC_DIGITS && $urandom_range(0, 2) != 0)
						s.insert(s.size(), CH_ZERO);
					else
						s.insert(s.size(),
							all_nines ? CH_NINE : char_t'(CH_ZERO + $urandom_range(0, 9)));
				end
			end
			if (kind >= 82) begin
				pos = $urandom_range(0, s.size() - 1);
				case ($urandom_range(0, 2))
					0: s[pos] = char_t'($urandom_range(0, 255));
					1: s.insert(pos, CH_MINUS);
					default: s.insert(pos, CH_POINT);
				endcase
			end
		end
		add_chars(s);
	endtask

	task automatic queue_random_chars(input int count);
		int start;
		start = chars_queued;
		while (chars_queued - start < count)
			queue_random_string();
	endtask

	task automatic wait_drained();
		while (pending_chars.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Driver: hold an offered character until its transfer, then advance.
	always @(negedge clk) begin
		if (!arst_n) begin
			text.valid <= 1'b0;
		end else if (text.valid && chars_taken < chars_offered) begin
		end else if (pending_chars.size() == 0 || skip_cycle()) begin
			text.valid <= 1'b0;
		end else begin
			text.valid <= 1'b1;
			text.char_code <= pending_chars[0].code;
			text.last_char <= pending_chars[0].last;
			chars_offered++;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else if (hold_left > 0) begin
			result.ready <= 1'b0;
			hold_left--;
		end else if (hold_off_req) begin
			result.ready <= 1'b0;
			hold_left = HOLD_OFF_CYCLES;
			hold_off_req = 1'b0;
		end else begin
			result.ready <= !skip_cycle();
		end
	end

	always @(posedge clk) begin
		if (arst_n && text.valid && text.ready) begin
			predict_char(text.char_code, text.last_char);
			pending_chars.delete(0);
			chars_taken++;
		end
	end

	always @(posedge clk) begin : check_results
		fixed_result_t want;
		if (arst_n && result.valid && result.ready) begin
			if (expected_results.size() == 0) begin
				want.value = '0;
				want.bad = 1'b0;
				report_mismatch("unexpected result", want);
			end else begin
				want = expected_results.pop_front();
				if (result.scaled_value !== want.value)
					report_mismatch("scaled_value", want);
				if (result.malformed !== want.bad)
					report_mismatch("malformed", want);
			end
		end
	end

	initial begin
		text.valid = 1'b0;
		text.char_code = '0;
		text.last_char = 1'b0;
		result.ready = 1'b0;
		clear_parse();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		queue_text("-");
		queue_text(".");
		queue_text("9");
		queue_text("-0");
		queue_text("5.");
		queue_text("-.5");
		queue_text("5..");
		queue_text("1-");
		queue_text("1.00000");
		queue_text("2.00009");
		queue_text("x7");
		wait_drained();

		queue_random_chars(350);
		wait_drained();

		calm = 1'b1;
		queue_random_chars(300);
		while (pending_chars.size() != 0)
			@(posedge clk);
		calm = 1'b0;

		hold_off_req = 1'b1;
		queue_random_chars(420);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
